FILE: hw/rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  // Number of payload bytes between the sync pair and the check byte.
  localparam int unsigned PAYLOAD_LENGTH = 6;
  localparam int unsigned IDX_W = $clog2(PAYLOAD_LENGTH);

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] TYPE_STATUS = 8'h81;

  // Fixed payload positions used by a status frame.
  localparam int unsigned POS_TYPE    = 0;
  localparam int unsigned POS_FLAGS   = 2;
  localparam int unsigned POS_BATTERY = 3;
  localparam int unsigned POS_CUR_A   = 4;
  localparam int unsigned POS_CUR_B   = 5;

  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_PAYLOAD,
    PH_CHECK
  } rx_phase_e;

  typedef enum logic [1:0] {
    FS_GOOD,
    FS_CRC_BAD,
    FS_UNKNOWN_TYPE
  } frame_status_e;

  typedef struct packed {
    logic [7:0] current_b;
    logic [7:0] current_a;
    logic [7:0] battery;
    logic [7:0] flags;
    logic [1:0] status;
  } sfr_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/status_frame_receiver_core.sv
`default_nettype none

// Channel     Direction  tdata fields (lowest bit up)                      Notes
// s_axis      in         rx_byte[7:0]                                      one link byte
// m_axis      out        frame_status[1:0], arm_a_seen, fire_a_on,         one item per frame
//                        arm_b_seen, fire_b_on, key_present, load_a_present,
//                        load_b_present, any_fault, battery_tenths_volt[7:0],
//                        current_a_tenths[7:0], current_b_tenths[7:0], zeros
//
// A link byte may follow in every cycle unless the input stalls.
// The check byte of a frame produces its result item in the result register
// in the cycle after it is accepted; the CRC step is one byte-wide update.
// Reset (rst_ni low, asynchronous) returns the receiver to the sync hunt with
// the CRC cleared and no result pending.
// The input stalls only while a result is held and the output side is not ready;
// a held result is replaced in the same cycle that it is taken.
module status_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_status[1:0], arm_a_seen[2], fire_a_on[3], arm_b_seen[4], fire_b_on[5],
  // key_present[6], load_a_present[7], load_b_present[8], any_fault[9],
  // battery_tenths_volt[17:10], current_a_tenths[25:18], current_b_tenths[33:26]
  output logic [sfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Receiver state.
  sfr_pkg::rx_phase_e             phase_q, phase_d;
  logic [sfr_pkg::IDX_W-1:0]      byte_index_q, byte_index_d;
  logic [7:0]                     crc_q, crc_d;
  logic [7:0]                     payload_q [sfr_pkg::PAYLOAD_LENGTH];

  // Result register in front of the output channel.
  logic                           out_valid_q, out_valid_d;
  sfr_pkg::sfr_result_t           result_q, result_d;

  logic                           in_accept;
  logic                           last_payload;
  logic [7:0]                     crc_next;

  // The input is free whenever the result register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign last_payload  = byte_index_q >= sfr_pkg::IDX_W'(sfr_pkg::PAYLOAD_LENGTH - 1);

  sfr_crc8 u_crc8 (
    .crc_i  (crc_q),
    .data_i (s_axis_tdata),
    .crc_o  (crc_next)
  );

  // Next-state logic of the frame receiver.
  always_comb begin
    phase_d      = phase_q;
    byte_index_d = byte_index_q;
    crc_d        = crc_q;
    if (in_accept) begin
      case (phase_q)
        sfr_pkg::PH_HUNT: begin
          if (s_axis_tdata == sfr_pkg::SYNC_FIRST) begin
            phase_d      = sfr_pkg::PH_SYNC2;
            byte_index_d = '0;
          end
        end
        sfr_pkg::PH_SYNC2: begin
          // A wrong second byte drops back to the hunt without being
          // looked at again as a first sync byte.
          if (s_axis_tdata == sfr_pkg::SYNC_SECOND) begin
            phase_d      = sfr_pkg::PH_PAYLOAD;
            byte_index_d = '0;
            crc_d        = '0;
          end else begin
            phase_d = sfr_pkg::PH_HUNT;
          end
        end
        sfr_pkg::PH_PAYLOAD: begin
          crc_d = crc_next;
          if (last_payload) begin
            phase_d      = sfr_pkg::PH_CHECK;
            byte_index_d = '0;
          end else begin
            byte_index_d = byte_index_q + 1'b1;
          end
        end
        sfr_pkg::PH_CHECK: begin
          phase_d      = sfr_pkg::PH_HUNT;
          byte_index_d = '0;
          crc_d        = '0;
        end
        default: begin
          phase_d = sfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Output logic: build the result item when the check byte arrives.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    result_d    = result_q;
    if (in_accept && (phase_q == sfr_pkg::PH_CHECK)) begin
      out_valid_d = 1'b1;
      result_d    = '0;
      if (crc_q != s_axis_tdata) begin
        result_d.status = sfr_pkg::FS_CRC_BAD;
      end else if (payload_q[sfr_pkg::POS_TYPE] != sfr_pkg::TYPE_STATUS) begin
        result_d.status = sfr_pkg::FS_UNKNOWN_TYPE;
      end else begin
        result_d.status    = sfr_pkg::FS_GOOD;
        result_d.flags     = payload_q[sfr_pkg::POS_FLAGS];
        result_d.battery   = payload_q[sfr_pkg::POS_BATTERY];
        result_d.current_a = payload_q[sfr_pkg::POS_CUR_A];
        result_d.current_b = payload_q[sfr_pkg::POS_CUR_B];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfr_pkg::PH_HUNT;
      byte_index_q <= '0;
      crc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      byte_index_q <= byte_index_d;
      crc_q        <= crc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload bytes and the result carry no reset; every payload slot is
  // written within a frame before the check byte reads it.
  always_ff @(posedge clk_i) begin
    if (in_accept && (phase_q == sfr_pkg::PH_PAYLOAD)) begin
      payload_q[byte_index_q] <= s_axis_tdata;
    end
    result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(sfr_pkg::OUT_TDATA_W - $bits(sfr_pkg::sfr_result_t))'(0), result_q};

`ifndef SYNTH
  // A check byte always leaves a result item behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (phase_q == sfr_pkg::PH_CHECK)) |=> m_axis_tvalid)
    else $error("check byte did not produce a result item");

  // The last payload byte moves the receiver to the check byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (phase_q == sfr_pkg::PH_PAYLOAD) && last_payload)
      |=> (phase_q == sfr_pkg::PH_CHECK))
    else $error("payload count did not end at the check byte");

  // The payload slot counter is only nonzero while collecting payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != sfr_pkg::PH_PAYLOAD) |-> (byte_index_q == '0))
    else $error("payload index left nonzero outside the payload phase");

  // A rejected frame carries nothing but its status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (result_q.status != sfr_pkg::FS_GOOD))
      |-> ((result_q.flags == '0) && (result_q.battery == '0)
           && (result_q.current_a == '0) && (result_q.current_b == '0)))
    else $error("rejected frame carries measurement data");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_crc8.sv
`default_nettype none

// One byte step of the reflected CRC-8, least significant bit first.
module sfr_crc8 (
  input  wire logic [7:0] crc_i,
  input  wire logic [7:0] data_i,
  output logic      [7:0] crc_o
);

  always_comb begin
    logic [7:0] crc;
    logic [7:0] data;
    crc  = crc_i;
    data = data_i;
    for (int b = 0; b < 8; b++) begin
      if ((crc[0] ^ data[0]) == 1'b1) begin
        crc = (crc >> 1) ^ sfr_pkg::CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
      data = data >> 1;
    end
    crc_o = crc;
  end

endmodule

`default_nettype wire

FILE: tb/tb_status_frame_receiver_core.sv
`timescale 1ns / 1ps

module tb_status_frame_receiver_core;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Link bytes to queue in total, and how many of the last ones go without idling.
  localparam int unsigned LINK_BYTES_TOTAL = 1050;
  localparam int unsigned CALM_BYTES = 150;
  // Queue position of the check byte of the first directed frame.
  localparam int unsigned FIRST_CHECK_POS = 2 + sfr_pkg::PAYLOAD_LENGTH;

  typedef struct {
    logic [7:0] value;
    bit         wait_drain;  // hold this byte back until every frame result is in
  } link_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata = 8'h00;  // rx_byte[7:0]
  logic m_axis_tready = 1'b0;
  wire s_axis_tready;
  wire m_axis_tvalid;
  // frame_status[1:0], eight status flags[9:2], battery_tenths_volt[17:10],
  // current_a_tenths[25:18], current_b_tenths[33:26], zeros[39:34]
  wire [sfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  link_item_t link_bytes_q[$];
  sfr_pkg::sfr_result_t frame_results_q[$];

  // Receiver state as the testbench tracks it.
  sfr_pkg::rx_phase_e frame_phase = sfr_pkg::PH_HUNT;
  logic [sfr_pkg::IDX_W-1:0] slot = '0;
  logic [7:0] payload_bytes [sfr_pkg::PAYLOAD_LENGTH];
  logic [7:0] crc_acc = 8'h00;

  int unsigned failures = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;
  link_item_t next_item;

  status_frame_receiver_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Reflected CRC-8 over one byte, least significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ sfr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic string flag_name(input int idx);
    case (idx)
      0: return "arm_a_seen";
      1: return "fire_a_on";
      2: return "arm_b_seen";
      3: return "fire_b_on";
      4: return "key_present";
      5: return "load_a_present";
      6: return "load_b_present";
      default: return "any_fault";
    endcase
  endfunction

  // Steps the tracked receiver by one accepted link byte; the check byte of a
  // frame leaves one expected result behind.
  task automatic decode_link_byte(input logic [7:0] b);
    sfr_pkg::sfr_result_t want;
    case (frame_phase)
      sfr_pkg::PH_HUNT: begin
        if (b == sfr_pkg::SYNC_FIRST) begin
          frame_phase = sfr_pkg::PH_SYNC2;
          slot = '0;
        end
      end
      sfr_pkg::PH_SYNC2: begin
        // A wrong second sync byte is not looked at again as a first one.
        if (b == sfr_pkg::SYNC_SECOND) begin
          frame_phase = sfr_pkg::PH_PAYLOAD;
          slot = '0;
          crc_acc = 8'h00;
        end else begin
          frame_phase = sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_PAYLOAD: begin
        payload_bytes[slot] = b;
        crc_acc = crc8_update(crc_acc, b);
        if (slot >= sfr_pkg::IDX_W'(sfr_pkg::PAYLOAD_LENGTH - 1)) begin
          frame_phase = sfr_pkg::PH_CHECK;
          slot = '0;
        end else begin
          slot = slot + 1'b1;
        end
      end
      default: begin
        want = '0;
        if (crc_acc != b) begin
          want.status = sfr_pkg::FS_CRC_BAD;
        end else if (payload_bytes[sfr_pkg::POS_TYPE] != sfr_pkg::TYPE_STATUS) begin
          want.status = sfr_pkg::FS_UNKNOWN_TYPE;
        end else begin
          want.status = sfr_pkg::FS_GOOD;
          want.flags = payload_bytes[sfr_pkg::POS_FLAGS];
          want.battery = payload_bytes[sfr_pkg::POS_BATTERY];
          want.current_a = payload_bytes[sfr_pkg::POS_CUR_A];
          want.current_b = payload_bytes[sfr_pkg::POS_CUR_B];
        end
        frame_results_q.push_back(want);
        frame_phase = sfr_pkg::PH_HUNT;
        slot = '0;
        crc_acc = 8'h00;
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    failures++;
    if (failures <= 10) begin
      $display("mismatch at %0t: %s expected 0x%02h, got 0x%02h", $realtime, what, want, got);
    end
  endtask

  task automatic check_result(input logic [sfr_pkg::OUT_TDATA_W-1:0] data);
    sfr_pkg::sfr_result_t want;
    sfr_pkg::sfr_result_t got;
    got = sfr_pkg::sfr_result_t'(data[$bits(sfr_pkg::sfr_result_t)-1:0]);
    if (frame_results_q.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch at %0t: result 0x%010h with no frame pending", $realtime, data);
      end
    end else begin
      want = frame_results_q.pop_front();
      if (got.status != want.status) begin
        note_mismatch("frame_status", 8'(want.status), 8'(got.status));
      end
      for (int i = 0; i < 8; i++) begin
        if (got.flags[i] != want.flags[i]) begin
          note_mismatch(flag_name(i), 8'(want.flags[i]), 8'(got.flags[i]));
        end
      end
      if (got.battery != want.battery) begin
        note_mismatch("battery_tenths_volt", want.battery, got.battery);
      end
      if (got.current_a != want.current_a) begin
        note_mismatch("current_a_tenths", want.current_a, got.current_a);
      end
      if (got.current_b != want.current_b) begin
        note_mismatch("current_b_tenths", want.current_b, got.current_b);
      end
      if (data[sfr_pkg::OUT_TDATA_W-1:$bits(sfr_pkg::sfr_result_t)] != '0) begin
        note_mismatch("padding", 8'h00,
                      8'(data[sfr_pkg::OUT_TDATA_W-1:$bits(sfr_pkg::sfr_result_t)]));
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] v, input bit drain);
    link_item_t it;
    it.value = v;
    it.wait_drain = drain;
    link_bytes_q.push_back(it);
  endtask

  // Queues one whole frame; a nonzero crc_flip spoils the check byte.
  task automatic add_frame(input logic [7:0] ftype, input logic [7:0] flags,
                           input logic [7:0] battery, input logic [7:0] cur_a,
                           input logic [7:0] cur_b, input logic [7:0] crc_flip,
                           input bit drain);
    logic [7:0] body [sfr_pkg::PAYLOAD_LENGTH];
    logic [7:0] crc;
    for (int i = 0; i < sfr_pkg::PAYLOAD_LENGTH; i++) begin
      body[i] = 8'($urandom);
    end
    body[sfr_pkg::POS_TYPE] = ftype;
    body[sfr_pkg::POS_FLAGS] = flags;
    body[sfr_pkg::POS_BATTERY] = battery;
    body[sfr_pkg::POS_CUR_A] = cur_a;
    body[sfr_pkg::POS_CUR_B] = cur_b;
    crc = 8'h00;
    add_byte(sfr_pkg::SYNC_FIRST, drain);
    add_byte(sfr_pkg::SYNC_SECOND, 1'b0);
    for (int i = 0; i < sfr_pkg::PAYLOAD_LENGTH; i++) begin
      crc = crc8_update(crc, body[i]);
      add_byte(body[i], 1'b0);
    end
    add_byte(crc ^ crc_flip, 1'b0);
  endtask

  task automatic add_random_frame(input bit drain);
    logic [7:0] ftype;
    logic [7:0] flip;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    ftype = sfr_pkg::TYPE_STATUS;
    flip = 8'h00;
    if (pick >= 8) begin
      do ftype = 8'($urandom); while (ftype == sfr_pkg::TYPE_STATUS);
    end else if (pick >= 6) begin
      flip = 8'($urandom_range(1, 255));
    end
    add_frame(ftype, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), flip, drain);
  endtask

  // Line noise: loose bytes, a broken sync pair, or a frame cut short.
  task automatic add_noise();
    int unsigned count;
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: begin
        count = $urandom_range(1, 6);
        repeat (count) add_byte(8'($urandom), 1'b0);
      end
      1: begin
        do b = 8'($urandom); while (b == sfr_pkg::SYNC_SECOND);
        add_byte(sfr_pkg::SYNC_FIRST, 1'b0);
        add_byte(b, 1'b0);
      end
      default: begin
        add_byte(sfr_pkg::SYNC_FIRST, 1'b0);
        add_byte(sfr_pkg::SYNC_SECOND, 1'b0);
        count = $urandom_range(0, sfr_pkg::PAYLOAD_LENGTH - 1);
        repeat (count) add_byte(8'($urandom), 1'b0);
      end
    endcase
  endtask

  // Sender: presents the next queued byte whenever the current one is taken,
  // with random idle bursts until the closing stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
      send_gap = 0;
      calm <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_link_byte(s_axis_tdata);
      end
      calm <= (link_bytes_q.size() < CALM_BYTES);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (link_bytes_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (link_bytes_q[0].wait_drain && frame_results_q.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 14);
          s_axis_tvalid <= 1'b0;
        end else begin
          next_item = link_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_item.value;
        end
      end
    end
  end

  // Result side: checks every accepted result and stalls in random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned frames;
    frames = 0;

    // Directed part: a status frame with every field at its top value and
    // payload byte 1 at zero, a doubled first sync byte, a frame with a bad
    // check byte, and a frame whose type differs from status by one bit.
    add_frame(sfr_pkg::TYPE_STATUS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
    link_bytes_q[3].value = 8'h00;
    add_byte(sfr_pkg::SYNC_FIRST, 1'b0);
    add_byte(sfr_pkg::SYNC_FIRST, 1'b0);
    add_frame(sfr_pkg::TYPE_STATUS, 8'hA5, 8'h00, 8'h7F, 8'h80, 8'h01, 1'b0);
    add_frame(8'h80, 8'h5A, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0);

    // Random part: mostly whole frames with random content, the rest noise.
    // Now and then the sender waits for the result side to drain.
    while (link_bytes_q.size() < LINK_BYTES_TOTAL) begin
      if ($urandom_range(0, 3) == 0) begin
        add_noise();
      end else begin
        add_random_frame(frames == 0 || frames % 37 == 0);
        frames++;
      end
    end

    // The directed frame above is rebuilt so its check byte still matches
    // after payload byte 1 was forced to zero.
    link_bytes_q[FIRST_CHECK_POS].value = 8'h00;
    for (int i = 2; i < FIRST_CHECK_POS; i++) begin
      link_bytes_q[FIRST_CHECK_POS].value =
        crc8_update(link_bytes_q[FIRST_CHECK_POS].value, link_bytes_q[i].value);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(link_bytes_q.size() == 0 && !s_axis_tvalid && frame_results_q.size() == 0)) begin
      @(posedge clk_i);
    end
    // The result is loaded in the cycle after its check byte is accepted; a further
    // wait catches any stray result.
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
